### rtl/vpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tables for the VGA palette DAC.
// No dependencies; imported by every rtl module and the checker.
package vpd_pkg;

  // Palette depth must be a power of two; indices are taken modulo it.
  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned PAL_AW    = $clog2(PAL_DEPTH);

  // transaction kinds
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // port selects
  localparam logic [1:0] PORT_MASK   = 2'd0;
  localparam logic [1:0] PORT_RSTATE = 2'd1;
  localparam logic [1:0] PORT_WADDR  = 2'd2;
  localparam logic [1:0] PORT_DATA   = 2'd3;

  // component steps
  localparam logic [1:0] STEP_RED   = 2'd0;
  localparam logic [1:0] STEP_GREEN = 2'd1;
  localparam logic [1:0] STEP_BLUE  = 2'd2;

  localparam logic [5:0] COMP_MASK = 6'h3f;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] port_select;
    logic [7:0] write_data;
    logic [7:0] pixel_index;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [23:0] color_rgb24;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_BYTE,
    KIND_COMP,
    KIND_RGB
  } res_kind_e;

  // index 2 red, 1 green, 0 blue
  typedef logic [2:0][5:0] rgb18_t;

  typedef struct packed {
    logic            vld;
    res_kind_e       kind;
    logic [7:0]      byte_val;
    logic [1:0]      comp;
  } s1_t;

  typedef struct packed {
    logic              rd_en;
    logic [PAL_AW-1:0] rd_addr;
    logic [2:0]        wr_en;
    logic [PAL_AW-1:0] wr_addr;
    logic [5:0]        wr_data;
  } ram_req_t;

  // 6-bit to 8-bit expansion, (c*255+31)/63, built at elaboration
  function automatic logic [63:0][7:0] build_exp6_lut();
    logic [63:0][7:0] lut;
    for (int i = 0; i < 64; i++) begin
      lut[i] = 8'((i * 255 + 31) / 63);
    end
    return lut;
  endfunction

  localparam logic [63:0][7:0] EXP6_LUT = build_exp6_lut();

endpackage

### rtl/vpd_pal_ram.sv
`timescale 1ns / 1ps
// Palette store: one 6-bit memory per component with per-entry valid bits.
// Depends on vpd_pkg.
module vpd_pal_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vpd_pkg::ram_req_t ram_req_i,
  output vpd_pkg::rgb18_t   rd_rgb_o
);
  import vpd_pkg::*;

  logic [5:0]           mem_q [3][PAL_DEPTH];
  logic [PAL_DEPTH-1:0] vld_q;
  logic [5:0]           rd_data_q [3];
  logic                 rd_vld_q;
  logic                 wr_any;
  logic                 wr_entry_vld;

  assign wr_any       = |ram_req_i.wr_en;
  assign wr_entry_vld = vld_q[ram_req_i.wr_addr];

  // first write to an entry also zeroes the other two components
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (wr_any && (ram_req_i.wr_en[c] || !wr_entry_vld)) begin
        mem_q[c][ram_req_i.wr_addr] <= ram_req_i.wr_en[c] ? ram_req_i.wr_data : 6'd0;
      end
      if (ram_req_i.rd_en) begin
        rd_data_q[c] <= mem_q[c][ram_req_i.rd_addr];
      end
    end
  end

  // unwritten entries read as zero until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_any) begin
        vld_q[ram_req_i.wr_addr] <= 1'b1;
      end
      if (ram_req_i.rd_en) begin
        rd_vld_q <= vld_q[ram_req_i.rd_addr];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rd_rgb_o[c] = rd_vld_q ? rd_data_q[c] : 6'd0;
    end
  end

endmodule

### rtl/vpd_ctrl.sv
`timescale 1ns / 1ps
// Port register file and transaction decode: mask, addresses, component
// step and mode; drives the palette store and the stage register. Uses vpd_pkg.
module vpd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  vpd_pkg::req_t     req_i,
  output logic              busy_o,
  output vpd_pkg::ram_req_t ram_req_o,
  output vpd_pkg::s1_t      s1_o
);
  import vpd_pkg::*;

  localparam logic [7:0] STATE_READ_MODE = 8'h03;

  logic       busy_q;
  logic [7:0] mask_q, mask_d;
  logic [7:0] raddr_q, raddr_d;
  logic [7:0] waddr_q, waddr_d;
  logic [1:0] step_q, step_d;
  logic       rmode_q, rmode_d;
  s1_t        s1_q, s1_d;
  logic       accept;
  logic [7:0] lookup_idx;

  assign accept     = start_i && !busy_q;
  assign lookup_idx = req_i.pixel_index & mask_q;

  always_comb begin
    mask_d  = mask_q;
    raddr_d = raddr_q;
    waddr_d = waddr_q;
    step_d  = step_q;
    rmode_d = rmode_q;

    ram_req_o         = '0;
    ram_req_o.rd_addr = raddr_q[PAL_AW-1:0];
    ram_req_o.wr_addr = waddr_q[PAL_AW-1:0];
    ram_req_o.wr_data = req_i.write_data[5:0] & COMP_MASK;

    s1_d          = '0;
    s1_d.vld      = accept;
    s1_d.kind     = KIND_ZERO;
    s1_d.comp     = step_q;

    if (accept) begin
      case (req_i.mode)
        MODE_READ: begin
          case (req_i.port_select)
            PORT_MASK: begin
              s1_d.kind     = KIND_BYTE;
              s1_d.byte_val = mask_q;
            end
            PORT_RSTATE: begin
              s1_d.kind     = KIND_BYTE;
              s1_d.byte_val = rmode_q ? STATE_READ_MODE : 8'd0;
            end
            PORT_WADDR: begin
              s1_d.kind     = KIND_BYTE;
              s1_d.byte_val = waddr_q;
            end
            PORT_DATA: begin
              // a stray step of 3 reads zero and leaves the step alone
              if (step_q <= STEP_BLUE) begin
                ram_req_o.rd_en = 1'b1;
                s1_d.kind       = KIND_COMP;
                if (step_q == STEP_BLUE) begin
                  raddr_d = raddr_q + 8'd1;
                  step_d  = STEP_RED;
                end else begin
                  step_d = step_q + 2'd1;
                end
              end
            end
            default: ;
          endcase
        end
        MODE_WRITE: begin
          case (req_i.port_select)
            PORT_MASK: begin
              mask_d = req_i.write_data;
            end
            PORT_RSTATE: begin
              raddr_d = req_i.write_data;
              waddr_d = req_i.write_data + 8'd1;
              step_d  = STEP_RED;
              rmode_d = 1'b1;
            end
            PORT_WADDR: begin
              waddr_d = req_i.write_data;
              raddr_d = req_i.write_data - 8'd1;
              step_d  = STEP_RED;
              rmode_d = 1'b0;
            end
            PORT_DATA: begin
              if (step_q <= STEP_BLUE) begin
                ram_req_o.wr_en = 3'b100 >> step_q;
                if (step_q == STEP_BLUE) begin
                  waddr_d = waddr_q + 8'd1;
                  step_d  = STEP_RED;
                end else begin
                  step_d = step_q + 2'd1;
                end
              end
            end
            default: ;
          endcase
        end
        MODE_LOOKUP: begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = lookup_idx[PAL_AW-1:0];
          s1_d.kind         = KIND_RGB;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      mask_q  <= 8'hff;
      raddr_q <= 8'd0;
      waddr_q <= 8'd0;
      step_q  <= STEP_RED;
      rmode_q <= 1'b1;
      s1_q    <= '0;
    end else begin
      busy_q  <= 1'b0;
      mask_q  <= mask_d;
      raddr_q <= raddr_d;
      waddr_q <= waddr_d;
      step_q  <= step_d;
      rmode_q <= rmode_d;
      s1_q    <= s1_d;
    end
  end

  assign busy_o = busy_q;
  assign s1_o   = s1_q;

endmodule

### rtl/vpd_expand.sv
`timescale 1ns / 1ps
// Result stage: picks the port byte or component, expands looked-up
// colours to 8 bits per channel and registers the result. Uses vpd_pkg.
module vpd_expand (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vpd_pkg::s1_t    s1_i,
  input  vpd_pkg::rgb18_t rgb_i,
  output logic            done_o,
  output vpd_pkg::rsp_t   rsp_o
);
  import vpd_pkg::*;

  logic       done_q;
  rsp_t       rsp_q, rsp_d;
  logic [1:0] comp_idx;

  // step 0 is red, which sits at the top of the word
  assign comp_idx = STEP_BLUE - s1_i.comp;

  always_comb begin
    rsp_d = '0;
    case (s1_i.kind)
      KIND_ZERO: ;
      KIND_BYTE: rsp_d.read_data = s1_i.byte_val;
      KIND_COMP: rsp_d.read_data = {2'b00, rgb_i[comp_idx]};
      KIND_RGB: begin
        rsp_d.color_rgb24 = {EXP6_LUT[rgb_i[2]], EXP6_LUT[rgb_i[1]],
                             EXP6_LUT[rgb_i[0]]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### rtl/vga_palette_dac_top.sv
`timescale 1ns / 1ps
// VGA palette DAC, top level: port/lookup decode, palette store, result stage.
// Depends on vpd_pkg, vpd_ctrl, vpd_pal_ram, vpd_expand.
//
// Usage:
//   A transaction is taken on a rising edge with start_i high and busy_o low.
//   req_i carries the kind (port read, port write, pixel lookup), the port,
//   the write byte and the dot index. busy_o is high only during reset and
//   the first cycle after it, so one transaction per clock is sustained.
//   Every transaction gives exactly one result: done_o is high for one cycle
//   with rsp_o; port writes and the unused kind return zeros. The decode
//   register and the registered palette read lie side by side, and the
//   result register follows them.
//   The receiver cannot stall; a result is gone after its cycle.
//   Reset clears the palette to black (per-entry valid bits, no sweep), sets
//   the pixel mask to 0xff, both addresses and the component step to zero
//   and the DAC to read mode.
module vga_palette_dac_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  vpd_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output vpd_pkg::rsp_t rsp_o
);
  import vpd_pkg::*;

  ram_req_t ram_req;
  s1_t      s1;
  rgb18_t   rd_rgb;

  vpd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .req_i     (req_i),
    .busy_o    (busy_o),
    .ram_req_o (ram_req),
    .s1_o      (s1)
  );

  vpd_pal_ram u_pal_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ram_req_i (ram_req),
    .rd_rgb_o  (rd_rgb)
  );

  vpd_expand u_expand (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1),
    .rgb_i  (rd_rgb),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

### rtl/vpd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the palette DAC, bound to the top level.
// Depends on vpd_pkg and vga_palette_dac_top.
module vpd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input vpd_pkg::req_t req_i,
  input logic          busy_o,
  input logic          done_o,
  input vpd_pkg::rsp_t rsp_o
);
  import vpd_pkg::*;

  // each accepted transaction is answered by a done_o strobe
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without a transaction");

  a_colour_only_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_i.mode, 2) != MODE_LOOKUP) |-> rsp_o.color_rgb24 == 24'd0)
    else $error("colour on a non-lookup result");

  a_byte_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_i.mode, 2) != MODE_READ) |-> rsp_o.read_data == 8'd0)
    else $error("read byte on a non-read result");

  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy raised outside reset");

endmodule

bind vga_palette_dac_top vpd_checker u_vpd_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for vga_palette_dac_top: port reads/writes and pixel lookups.
// Holds its own palette/DAC-state predictor; depends on vpd_pkg and the rtl.
module tb_top;
  import vpd_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned ITEM_GOAL   = 600;
  localparam int unsigned MAX_REPORTS = 100;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start_i;
  req_t  req_i;
  logic  busy_o;
  logic  done_o;
  rsp_t  rsp_o;

  vga_palette_dac_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the DAC state
  rgb18_t      pal_shadow [PAL_DEPTH];
  logic [7:0]  dac_mask;
  logic [7:0]  dac_raddr;
  logic [7:0]  dac_waddr;
  logic [1:0]  dac_step;
  logic        dac_rmode;

  rsp_t        pending_rsp [$];
  bit          steady;
  int unsigned n_sent, n_lookup, n_pal_wr, n_port_rd, n_checked, n_err;
  int unsigned stall_cnt;

  function automatic void clear_shadow();
    for (int i = 0; i < PAL_DEPTH; i++) pal_shadow[i] = '0;
    dac_mask  = 8'hff;
    dac_raddr = '0;
    dac_waddr = '0;
    dac_step  = STEP_RED;
    dac_rmode = 1'b1;
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] c);
    return 8'((32'(c) * 255 + 31) / 63);
  endfunction

  // Works out the response of one transaction and advances the shadow state.
  function automatic rsp_t predict_dac(req_t r);
    rsp_t       o;
    rgb18_t     e;
    logic [1:0] lane;
    o    = '0;
    lane = 2'(STEP_BLUE - dac_step);  // red sits in the top lane
    case (r.mode)
      MODE_READ: begin
        case (r.port_select)
          PORT_MASK:   o.read_data = dac_mask;
          PORT_RSTATE: o.read_data = dac_rmode ? 8'd3 : 8'd0;
          PORT_WADDR:  o.read_data = dac_waddr;
          default: begin
            o.read_data = {2'b00, pal_shadow[dac_raddr][lane]};
            if (dac_step == STEP_BLUE) begin
              dac_raddr++;
              dac_step = STEP_RED;
            end else begin
              dac_step++;
            end
          end
        endcase
      end
      MODE_WRITE: begin
        case (r.port_select)
          PORT_MASK: dac_mask = r.write_data;
          PORT_RSTATE: begin
            dac_raddr = r.write_data;
            dac_waddr = r.write_data + 8'd1;
            dac_step  = STEP_RED;
            dac_rmode = 1'b1;
          end
          PORT_WADDR: begin
            dac_waddr = r.write_data;
            dac_raddr = r.write_data - 8'd1;
            dac_step  = STEP_RED;
            dac_rmode = 1'b0;
          end
          default: begin
            pal_shadow[dac_waddr][lane] = r.write_data[5:0];
            if (dac_step == STEP_BLUE) begin
              dac_waddr++;
              dac_step = STEP_RED;
            end else begin
              dac_step++;
            end
          end
        endcase
      end
      MODE_LOOKUP: begin
        e = pal_shadow[r.pixel_index & dac_mask];
        o.color_rgb24 = {widen6(e[2]), widen6(e[1]), widen6(e[0])};
      end
      default: ;  // unused kind: nothing changes, zeros back
    endcase
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t mk_req(logic [1:0] mode, logic [1:0] port, logic [7:0] data,
                                  logic [7:0] pix);
    req_t r;
    r.mode        = mode;
    r.port_select = port;
    r.write_data  = data;
    r.pixel_index = pix;
    return r;
  endfunction

  // Sends one transaction, records its expected response, then idles for a random gap, which may be zero.
  task automatic send_txn(input req_t r);
    int unsigned gap;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    pending_rsp.push_back(predict_dac(r));
    n_sent++;
    if (r.mode == MODE_LOOKUP) n_lookup++;
    if (r.mode == MODE_WRITE && r.port_select == PORT_DATA) n_pal_wr++;
    if (r.mode == MODE_READ) n_port_rd++;
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic port_wr(logic [1:0] port, logic [7:0] v);
    send_txn(mk_req(MODE_WRITE, port, v, 8'($urandom)));
  endtask

  task automatic port_rd(logic [1:0] port);
    send_txn(mk_req(MODE_READ, port, 8'($urandom), 8'($urandom)));
  endtask

  task automatic lookup(logic [7:0] pix);
    send_txn(mk_req(MODE_LOOKUP, 2'($urandom), 8'($urandom), pix));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_err++;
    // keep the log short if the design is badly broken
    if (n_err <= MAX_REPORTS)
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
  endtask

  // Result checker: every strobe must meet the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", {rsp_o.read_data, rsp_o.color_rgb24}, '0);
      end else begin
        want = pending_rsp.pop_front();
        n_checked++;
        if (rsp_o.read_data !== want.read_data)
          report_mismatch("read_data", 32'(rsp_o.read_data), 32'(want.read_data));
        if (rsp_o.color_rgb24 !== want.color_rgb24)
          report_mismatch("color_rgb24", 32'(rsp_o.color_rgb24), 32'(want.color_rgb24));
      end
    end
  end

  // Watchdog: too long without any transaction in either direction.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o && rst_ni) || done_o) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t watchdog: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("[vga_palette_dac_top] ERROR");
        $finish;
      end
    end
  end

  task automatic test_reset_values();
    port_rd(PORT_MASK);
    port_rd(PORT_RSTATE);
    port_rd(PORT_WADDR);
    port_rd(PORT_DATA);
    lookup(8'hff);
  endtask

  task automatic test_directed_ports();
    port_wr(PORT_WADDR, 8'hff);
    port_rd(PORT_RSTATE);           // write mode now
    port_rd(PORT_WADDR);
    port_wr(PORT_DATA, 8'hff);      // upper bits dropped
    port_wr(PORT_DATA, 8'h00);
    port_wr(PORT_DATA, 8'hea);
    port_rd(PORT_WADDR);            // wrapped past the top entry
    port_wr(PORT_RSTATE, 8'hff);
    port_rd(PORT_WADDR);
    repeat (4) port_rd(PORT_DATA);  // last one wraps to entry 0
    lookup(8'hff);
    port_wr(PORT_MASK, 8'h00);
    port_rd(PORT_MASK);
    lookup(8'hff);                  // masked down to entry 0
    port_wr(PORT_MASK, 8'hff);
    send_txn(mk_req(2'd3, PORT_DATA, 8'hff, 8'hff));
    send_txn(mk_req(2'd3, PORT_MASK, 8'h00, 8'h00));
    port_rd(PORT_MASK);
    port_wr(PORT_WADDR, 8'h00);
    port_rd(PORT_RSTATE);
  endtask

  // Well-formed load/read-back sequences with a sprinkle of noise.
  task automatic test_palette_rounds(int unsigned goal);
    logic [7:0]  base;
    int unsigned n;
    while (n_sent < goal) begin
      base = 8'($urandom);
      n    = $urandom_range(1, 4);
      if ($urandom_range(3) == 0) port_wr(PORT_MASK, 8'($urandom));
      port_wr(PORT_WADDR, base);
      repeat (3 * n + $urandom_range(0, 2) * ($urandom_range(3) == 0))
        port_wr(PORT_DATA, 8'($urandom));
      if ($urandom_range(4) == 0) send_txn(req_t'($urandom));
      port_wr(PORT_RSTATE, base);
      repeat (3 * n) port_rd(PORT_DATA);
      if ($urandom_range(1) == 0) port_rd(2'($urandom));
      for (int i = 0; i < n; i++) lookup(base + 8'(i));
    end
  endtask

  // Dot-clock style bursts of lookups, the first part back to back.
  task automatic test_pixel_stream(int unsigned goal);
    steady = 1'b1;
    port_wr(PORT_MASK, 8'hff);
    while (n_sent < goal) begin
      if (n_sent > goal - 60) steady = 1'b0;
      if ($urandom_range(15) == 0) port_wr(PORT_MASK, 8'($urandom));
      lookup(8'($urandom));
    end
    steady = 1'b0;
  endtask

  task automatic test_random_mix(int unsigned goal);
    req_t r;
    while (n_sent < goal) begin
      r = req_t'($urandom);
      if ($urandom_range(7) == 0) r.mode = 2'd3;
      else r.mode = 2'($urandom_range(MODE_READ, MODE_LOOKUP));
      send_txn(r);
    end
  endtask

  initial begin
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    req_i   <= '0;
    steady  = 1'b0;
    clear_shadow();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_directed_ports();
    test_palette_rounds(ITEM_GOAL / 2);
    test_pixel_stream(ITEM_GOAL / 2 + 150);
    test_random_mix(ITEM_GOAL + 25);

    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Ran %0d transactions: %0d lookups, %0d palette data writes, %0d port reads.",
             n_sent, n_lookup, n_pal_wr, n_port_rd);
    $display("%0d responses compared, %0d mismatches.", n_checked, n_err);
    if (n_err == 0) begin
      $display("[vga_palette_dac_top] OK");
    end else begin
      $display("[vga_palette_dac_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/vpd_pkg.sv
rtl/vpd_pal_ram.sv
rtl/vpd_ctrl.sv
rtl/vpd_expand.sv
rtl/vga_palette_dac_top.sv
rtl/vpd_checker.sv
bench/tb_top.sv
